// ===== sv/sfr_pkg.sv =====
package sfr_pkg;

    localparam int unsigned MODE_W     = 3;
    localparam int unsigned MASK_W     = 16;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned THR_COUNT  = 4;
    localparam int unsigned THR_IDX_W  = 2;
    localparam int unsigned CFG_IDX_W  = 4;

    localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_INIT   = 16'hFFFF;
    localparam logic [MASK_W-1:0] MASK_ONES  = 16'hFFFF;

    localparam logic [MODE_W-1:0] MODE_SET       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RESET_ALL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_NR    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR_NR  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REFRESH   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CHECK     = 3'd6;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [MASK_W-1:0] fault_bits;
        logic [CRC_W-1:0]  snap_crc;
    } item_t;

    // one byte, MSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    // low byte first
    function automatic logic [CRC_W-1:0] crc_word32(input logic [CRC_W-1:0] crc,
                                                    input logic [WORD_W-1:0] w);
        logic [CRC_W-1:0] c;
        c = crc;
        c = crc_byte(c, w[7:0]);
        c = crc_byte(c, w[15:8]);
        c = crc_byte(c, w[23:16]);
        c = crc_byte(c, w[31:24]);
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] crc_word16(input logic [CRC_W-1:0] crc,
                                                    input logic [MASK_W-1:0] w);
        logic [CRC_W-1:0] c;
        c = crc;
        c = crc_byte(c, w[7:0]);
        c = crc_byte(c, w[15:8]);
        return c;
    endfunction

    // state carried through the 16 threshold bytes (data part split off)
    function automatic logic [CRC_W-1:0] crc_zero16(input logic [CRC_W-1:0] crc);
        logic [CRC_W-1:0] c;
        c = crc;
        for (int i = 0; i < 16; i++)
        begin
            c = crc_byte(c, 8'h00);
        end
        return c;
    endfunction

endpackage

// ===== sv/shadow_fault_register_with_crc.sv =====
// A transaction accepted into the input register passes on to the result register, where its
// result is valid; out_stall can hold it in the input register before it passes on.
// Throughput: one transaction per cycle while unstalled; the CRC is one XOR network per stage.
// The snapshot bytes are folded into the CRC before the input register.
// Reset (rst_n low, async): mask 0, shadow 0xFFFF, stored CRC 0, thresholds 0,
// both stages empty.
module shadow_fault_register_with_crc
    import sfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]    cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic [MASK_W-1:0]    fault_bits,
    input  logic [WORD_W-1:0]    gyro_spike_count,
    input  logic [WORD_W-1:0]    accel_spike_count,
    input  logic [WORD_W-1:0]    buffer_fill_count,
    input  logic [WORD_W-1:0]    buffer_head_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [MASK_W-1:0]    fault_mask_out,
    output logic                 shadow_consistent,
    output logic [CRC_W-1:0]     crc_now,
    output logic                 crc_matches
);

    logic             item_valid;
    item_t            item;
    logic             core_ready;
    logic [CRC_W-1:0] thr_crc;

    sfr_thr_regs u_thr (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .thr_crc   (thr_crc)
    );

    sfr_in_stage u_in (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .fault_bits        (fault_bits),
        .gyro_spike_count  (gyro_spike_count),
        .accel_spike_count (accel_spike_count),
        .buffer_fill_count (buffer_fill_count),
        .buffer_head_index (buffer_head_index),
        .item_valid        (item_valid),
        .item              (item),
        .core_ready        (core_ready)
    );

    sfr_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item              (item),
        .core_ready        (core_ready),
        .thr_crc           (thr_crc),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .fault_mask_out    (fault_mask_out),
        .shadow_consistent (shadow_consistent),
        .crc_now           (crc_now),
        .crc_matches       (crc_matches)
    );

endmodule

// ===== sv/sfr_thr_regs.sv =====
module sfr_thr_regs
    import sfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]    cfg_wdata,
    output logic [CRC_W-1:0]     thr_crc
);

    logic [WORD_W-1:0] thr_reg [THR_COUNT];
    logic [CRC_W-1:0]  thr_crc_reg;
    logic [CRC_W-1:0]  thr_crc_next;
    logic              wr_hit;

    assign wr_hit = cfg_wr_en && (cfg_addr < CFG_IDX_W'(THR_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THR_COUNT; i++)
            begin
                thr_reg[i] <= '0;
            end
        end
        else if (wr_hit)
        begin
            thr_reg[cfg_addr[THR_IDX_W-1:0]] <= cfg_wdata;
        end
    end

    // data-only part of the threshold bytes, zero start state
    always_comb
    begin
        thr_crc_next = '0;
        for (int i = 0; i < THR_COUNT; i++)
        begin
            thr_crc_next = crc_word32(thr_crc_next, thr_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_crc_reg <= '0;
        else
            thr_crc_reg <= thr_crc_next;
    end

    assign thr_crc = thr_crc_reg;

endmodule

// ===== sv/sfr_in_stage.sv =====
module sfr_in_stage
    import sfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [MODE_W-1:0] mode,
    input  logic [MASK_W-1:0] fault_bits,
    input  logic [WORD_W-1:0] gyro_spike_count,
    input  logic [WORD_W-1:0] accel_spike_count,
    input  logic [WORD_W-1:0] buffer_fill_count,
    input  logic [WORD_W-1:0] buffer_head_index,
    output logic              item_valid,
    output item_t             item,
    input  logic              core_ready
);

    logic             valid_reg;
    logic             valid_next;
    item_t            item_reg;
    item_t            item_next;
    logic             load;
    logic [CRC_W-1:0] snap_crc;

    assign load     = !valid_reg || core_ready;
    assign in_stall = !load;

    always_comb
    begin
        snap_crc = crc_word32(CRC_INIT, gyro_spike_count);
        snap_crc = crc_word32(snap_crc, accel_spike_count);
        snap_crc = crc_word32(snap_crc, buffer_fill_count);
        snap_crc = crc_word32(snap_crc, buffer_head_index);
        item_next.mode       = mode;
        item_next.fault_bits = fault_bits;
        item_next.snap_crc   = snap_crc;
        valid_next = load ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/sfr_core.sv =====
module sfr_core
    import sfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  item_t             item,
    output logic              core_ready,
    input  logic [CRC_W-1:0]  thr_crc,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [MASK_W-1:0] fault_mask_out,
    output logic              shadow_consistent,
    output logic [CRC_W-1:0]  crc_now,
    output logic              crc_matches
);

    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic [MASK_W-1:0] shadow_reg;
    logic [MASK_W-1:0] shadow_next;
    logic [CRC_W-1:0]  stored_crc_reg;
    logic [CRC_W-1:0]  stored_crc_next;
    logic              refresh;
    logic              adv;
    logic [CRC_W-1:0]  pair_crc;
    logic [CRC_W-1:0]  crc_calc;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [MASK_W-1:0] fault_mask_out_reg;
    logic              shadow_consistent_reg;
    logic [CRC_W-1:0]  crc_now_reg;
    logic              crc_matches_reg;

    assign core_ready = !out_valid_reg || !out_stall;
    assign adv        = item_valid && core_ready;

    always_comb
    begin
        mask_next   = mask_reg;
        shadow_next = shadow_reg;
        refresh     = 1'b0;
        unique case (item.mode) inside
            MODE_SET:
            begin
                mask_next   = mask_reg | item.fault_bits;
                shadow_next = shadow_reg & ~item.fault_bits;
                refresh     = 1'b1;
            end
            MODE_CLEAR:
            begin
                mask_next   = mask_reg & ~item.fault_bits;
                shadow_next = shadow_reg | item.fault_bits;
                refresh     = 1'b1;
            end
            MODE_RESET_ALL:
            begin
                mask_next   = '0;
                shadow_next = MASK_ONES;
                refresh     = 1'b1;
            end
            MODE_SET_NR:
            begin
                mask_next   = mask_reg | item.fault_bits;
                shadow_next = shadow_reg & ~item.fault_bits;
            end
            MODE_CLEAR_NR:
            begin
                mask_next   = mask_reg & ~item.fault_bits;
                shadow_next = shadow_reg | item.fault_bits;
            end
            MODE_REFRESH:
            begin
                refresh = 1'b1;
            end
            default:
            begin
                refresh = 1'b0;
            end
        endcase
    end

    // CRC is linear: carry the state through the threshold bytes, add their data part
    always_comb
    begin
        pair_crc        = crc_word16(item.snap_crc, mask_next);
        pair_crc        = crc_word16(pair_crc, shadow_next);
        crc_calc        = crc_zero16(pair_crc) ^ thr_crc;
        stored_crc_next = refresh ? crc_calc : stored_crc_reg;
        out_valid_next  = adv ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '0;
            shadow_reg     <= MASK_ONES;
            stored_crc_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                mask_reg       <= mask_next;
                shadow_reg     <= shadow_next;
                stored_crc_reg <= stored_crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fault_mask_out_reg    <= mask_next;
            shadow_consistent_reg <= ((mask_next ^ shadow_next) == MASK_ONES);
            crc_now_reg           <= crc_calc;
            crc_matches_reg       <= (crc_calc == stored_crc_next);
        end
    end

    assign out_valid         = out_valid_reg;
    assign fault_mask_out    = fault_mask_out_reg;
    assign shadow_consistent = shadow_consistent_reg;
    assign crc_now           = crc_now_reg;
    assign crc_matches       = crc_matches_reg;

    a_reset_all: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (item.mode == MODE_RESET_ALL) |=>
            (mask_reg == '0) && (shadow_reg == MASK_ONES))
        else $error("reset-all did not restore the mask pair");

    a_check_holds: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (item.mode == MODE_CHECK) |=>
            $stable(mask_reg) && $stable(shadow_reg) && $stable(stored_crc_reg))
        else $error("check transaction changed state");

    a_refresh_match: assert property (@(posedge clk) disable iff (!rst_n)
        adv && refresh |=> out_valid_reg && crc_matches_reg)
        else $error("refreshed CRC does not match");

    a_mask_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (fault_mask_out_reg == mask_reg))
        else $error("reported mask differs from held mask");

endmodule
